// ----- rtl/core/mwd_pkg.sv -----
`timescale 1ns / 1ps

package mwd_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int MODE_W   = 3;
  localparam int PROD_W   = 33;  // Q1.15 * Q4.12, signed
  localparam int V_W      = 21;  // driven value in Q.15 units, signed
  localparam int MAG_W    = 20;  // magnitude of the driven value
  localparam int Y_W      = 22;  // shaped value before saturation, signed
  localparam int OUT_W    = 20;  // Q5.15 result
  localparam int Q_W      = 16;  // knee and exponential magnitudes

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_GAIN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_MODE = 8'd1;
  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = 16'd4096;
  localparam logic [MODE_W-1:0] SHAPE_MODE_RST = 3'd1;

  // Shape modes; the two unused codes behave as bypass
  localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HARD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FULL   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HALF   = 3'd5;

  // Soft knee regions
  localparam logic [1:0] KNEE_PASS  = 2'd0;
  localparam logic [1:0] KNEE_SAT   = 2'd1;
  localparam logic [1:0] KNEE_CURVE = 2'd2;

  // Q.15 constants
  localparam logic [MAG_W-1:0] HALF_Q15       = 20'd16384;
  localparam logic [MAG_W-1:0] THIRD_Q15      = 20'd10923;
  localparam logic [MAG_W-1:0] TWO_THIRDS_Q15 = 20'd21845;
  localparam logic signed [Y_W-1:0] OUT_MAX   = 22'sd327679;
  localparam logic signed [Y_W-1:0] OUT_MIN   = -22'sd327680;
  localparam logic [31:0] KNEE_BIAS = 32'd3221323776;  // 3*2^30 + 98304
  localparam logic [16:0] RECIP3    = 17'd43691;       // 2^17 / 3, rounded up

  // Exponential table
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int EXP_ADDR_W      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_FRAC_W      = 18;  // table spans 8.0 = 2^18 in Q.15
  localparam int EXP_S_W         = EXP_FRAC_W + EXP_IDX_W;

  typedef logic [Q_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  function automatic exp_tab_t build_exp_tab();
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    exp_tab_t    t;
    h    = (64'd8 << 32) / EXP_TABLE_DEPTH;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    // exp(-8/depth) by a truncated Taylor series in Q32
    term = ((term * h) >> 32) / 64'd1;  sum = sum - term;
    term = ((term * h) >> 32) / 64'd2;  sum = sum + term;
    term = ((term * h) >> 32) / 64'd3;  sum = sum - term;
    term = ((term * h) >> 32) / 64'd4;  sum = sum + term;
    term = ((term * h) >> 32) / 64'd5;  sum = sum - term;
    term = ((term * h) >> 32) / 64'd6;  sum = sum + term;
    term = ((term * h) >> 32) / 64'd7;  sum = sum - term;
    term = ((term * h) >> 32) / 64'd8;  sum = sum + term;
    term = ((term * h) >> 32) / 64'd9;  sum = sum - term;
    term = ((term * h) >> 32) / 64'd10; sum = sum + term;
    term = ((term * h) >> 32) / 64'd11; sum = sum - term;
    term = ((term * h) >> 32) / 64'd12; sum = sum + term;
    term = ((term * h) >> 32) / 64'd13; sum = sum - term;
    term = ((term * h) >> 32) / 64'd14; sum = sum + term;
    term = ((term * h) >> 32) / 64'd15; sum = sum - term;
    term = ((term * h) >> 32) / 64'd16; sum = sum + term;
    term = ((term * h) >> 32) / 64'd17; sum = sum - term;
    term = ((term * h) >> 32) / 64'd18; sum = sum + term;
    term = ((term * h) >> 32) / 64'd19; sum = sum - term;
    term = ((term * h) >> 32) / 64'd20; sum = sum + term;
    term = ((term * h) >> 32) / 64'd21; sum = sum - term;
    term = ((term * h) >> 32) / 64'd22; sum = sum + term;
    term = ((term * h) >> 32) / 64'd23; sum = sum - term;
    term = ((term * h) >> 32) / 64'd24; sum = sum + term;
    e    = 64'd1 << 32;
    t[0] = '0;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      e    = (e * sum + (64'd1 << 31)) >> 32;
      t[k] = Q_W'(((((64'd1 << 32) - e) * 64'd32768) + (64'd1 << 31)) >> 32);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();
  localparam logic [Q_W-1:0] EXP_TOP = EXP_TAB[EXP_TABLE_DEPTH];

  // Word after the drive stages
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [V_W-1:0]   v;
    logic [MAG_W-1:0]        mag;
    logic                    neg;
  } gain_word_t;

  // Word after the shaping stages
  typedef struct packed {
    gain_word_t     g;
    logic [1:0]     region;
    logic           big;
    logic [Q_W-1:0] knee_q;
    logic [Q_W-1:0] exp_y;
  } shape_word_t;

endpackage

// ----- rtl/core/mwd_gain.sv -----
`timescale 1ns / 1ps

module mwd_gain
  import mwd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]   gain,
  input  logic [MODE_W-1:0]   mode,
  output logic                out_valid,
  input  logic                out_ready,
  output gain_word_t          out_word
);

  logic                     vld1;
  logic                     vld2;
  logic                     adv1;
  logic                     adv2;
  logic signed [PROD_W-1:0] prod1;
  logic [MODE_W-1:0]        mode1;
  logic signed [PROD_W-1:0] sx;
  logic signed [PROD_W-1:0] gx;
  logic signed [PROD_W-1:0] rnd;
  logic signed [V_W-1:0]    v;
  logic signed [V_W-1:0]    v_abs;
  gain_word_t               word2;

  assign adv1      = !vld1 || adv2;
  assign adv2      = !vld2 || out_ready;
  assign in_ready  = adv1;
  assign out_valid = vld2;
  assign out_word  = word2;

  assign sx = {{(PROD_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign gx = {{(PROD_W - GAIN_W){1'b0}}, gain};

  // Round to nearest, ties upward: floor((p + 2048) / 4096)
  assign rnd   = prod1 + PROD_W'(2048);
  assign v     = rnd[PROD_W-1:12];
  assign v_abs = v[V_W-1] ? -v : v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (adv1) begin
        vld1 <= in_valid;
      end
      if (adv2) begin
        vld2 <= vld1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod1 <= sx * gx;
      mode1 <= mode;
    end
    if (adv2 && vld1) begin
      word2.mode <= mode1;
      word2.v    <= v;
      word2.mag  <= v_abs[MAG_W-1:0];
      word2.neg  <= v[V_W-1];
    end
  end

endmodule

// ----- rtl/core/mwd_shape.sv -----
`timescale 1ns / 1ps

module mwd_shape
  import mwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gain_word_t  in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output shape_word_t out_word
);

  logic vld3, vld4, vld5;
  logic adv3, adv4, adv5;

  // Stage 3: knee region and table lookup
  gain_word_t              g3;
  logic [1:0]              region3;
  logic                    big3;
  logic [15:0]             u3;
  logic [EXP_FRAC_W-1:0]   f3;
  logic [Q_W-1:0]          lo3;
  logic [Q_W-1:0]          hi3;

  // Stage 4: the two products
  gain_word_t              g4;
  logic [1:0]              region4;
  logic                    big4;
  logic [31:0]             uu4;
  logic [Q_W+EXP_FRAC_W-1:0] dp4;
  logic [Q_W-1:0]          lo4;

  shape_word_t             word5;

  logic [1:0]              region_c;
  logic [16:0]             a3x;
  logic [16:0]             u_c;
  logic [EXP_S_W-1:0]      s_c;
  logic [EXP_ADDR_W-1:0]   idx_c;
  logic [31:0]             knee_num;
  logic [32:0]             knee_div;
  logic [Q_W+EXP_FRAC_W:0] dp_rnd;
  logic [Q_W-1:0]          exp_c;

  assign adv3      = !vld3 || adv4;
  assign adv4      = !vld4 || adv5;
  assign adv5      = !vld5 || out_ready;
  assign in_ready  = adv3;
  assign out_valid = vld5;
  assign out_word  = word5;

  always_comb begin
    priority if (in_word.mag <= THIRD_Q15) begin
      region_c = KNEE_PASS;
    end else if (in_word.mag > TWO_THIRDS_Q15) begin
      region_c = KNEE_SAT;
    end else begin
      region_c = KNEE_CURVE;
    end
  end

  // U = 65536 - 3|x|; only meaningful inside the knee, where |x| < 2^15
  assign a3x = 17'(in_word.mag[14:0]) * 17'd3;
  assign u_c = 17'd65536 - a3x;

  // Table index and fraction from |x| * depth over a span of 2^18
  assign s_c   = EXP_S_W'(in_word.mag[EXP_FRAC_W-1:0]) * EXP_S_W'(EXP_TABLE_DEPTH);
  assign idx_c = EXP_ADDR_W'(s_c[EXP_S_W-1:EXP_FRAC_W]);

  // Knee: floor((3*2^30 - U^2 + 98304) / 2^16) / 3 by reciprocal
  assign knee_num = KNEE_BIAS - uu4;
  assign knee_div = 33'(knee_num[31:16]) * 33'(RECIP3);

  // Interpolation with round half up
  assign dp_rnd = (Q_W + EXP_FRAC_W + 1)'(dp4) + (Q_W + EXP_FRAC_W + 1)'(131072);
  assign exp_c  = lo4 + dp_rnd[Q_W+EXP_FRAC_W-1:EXP_FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (adv3) begin
        vld3 <= in_valid;
      end
      if (adv4) begin
        vld4 <= vld3;
      end
      if (adv5) begin
        vld5 <= vld4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      g3      <= in_word;
      region3 <= region_c;
      big3    <= in_word.mag[MAG_W-1:EXP_FRAC_W] != '0;
      u3      <= u_c[15:0];
      f3      <= s_c[EXP_FRAC_W-1:0];
      lo3     <= EXP_TAB[idx_c];
      hi3     <= EXP_TAB[idx_c + EXP_ADDR_W'(1)];
    end
    if (adv4 && vld3) begin
      g4      <= g3;
      region4 <= region3;
      big4    <= big3;
      uu4     <= 32'(u3) * 32'(u3);
      dp4     <= (Q_W + EXP_FRAC_W)'(hi3 - lo3) * (Q_W + EXP_FRAC_W)'(f3);
      lo4     <= lo3;
    end
    if (adv5 && vld4) begin
      word5.g      <= g4;
      word5.region <= region4;
      word5.big    <= big4;
      word5.knee_q <= knee_div[32:17];
      word5.exp_y  <= exp_c;
    end
  end

endmodule

// ----- rtl/core/mwd_select.sv -----
`timescale 1ns / 1ps

module mwd_select
  import mwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  shape_word_t      in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] sample_out
);

  logic                  vld6;
  logic                  adv6;
  logic [OUT_W-1:0]      out6;
  logic signed [Y_W-1:0] vs;
  logic signed [Y_W-1:0] ms;
  logic signed [Y_W-1:0] half_p;
  logic signed [Y_W-1:0] half_n;
  logic [MAG_W-1:0]      soft_mag;
  logic [MAG_W-1:0]      exp_mag;
  logic signed [Y_W-1:0] y;
  logic signed [Y_W-1:0] y_sat;

  assign adv6       = !vld6 || out_ready;
  assign in_ready   = adv6;
  assign out_valid  = vld6;
  assign sample_out = out6;

  assign vs     = Y_W'(in_word.g.v);
  assign ms     = $signed(Y_W'(in_word.g.mag));
  assign half_p = $signed(Y_W'(HALF_Q15));
  assign half_n = -half_p;

  always_comb begin
    unique case (in_word.region)
      KNEE_PASS:  soft_mag = in_word.g.mag;
      KNEE_SAT:   soft_mag = HALF_Q15;
      default:    soft_mag = MAG_W'(in_word.knee_q);
    endcase
  end

  assign exp_mag = in_word.big ? MAG_W'(EXP_TOP) : MAG_W'(in_word.exp_y);

  always_comb begin
    unique case (in_word.g.mode)
      MODE_HARD: begin
        priority if (vs > half_p) begin
          y = half_p;
        end else if (vs < half_n) begin
          y = half_n;
        end else begin
          y = vs;
        end
      end
      MODE_SOFT: y = in_word.g.neg ? -$signed(Y_W'(soft_mag)) : $signed(Y_W'(soft_mag));
      MODE_EXP:  y = in_word.g.neg ? -$signed(Y_W'(exp_mag)) : $signed(Y_W'(exp_mag));
      MODE_FULL: y = ms;
      MODE_HALF: y = in_word.g.neg ? '0 : vs;
      default:   y = vs;
    endcase
  end

  always_comb begin
    priority if (y > OUT_MAX) begin
      y_sat = OUT_MAX;
    end else if (y < OUT_MIN) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else if (adv6) begin
      vld6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv6 && in_valid) begin
      out6 <= y_sat[OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/multimode_waveshaper_distortion_unit.sv -----
`timescale 1ns / 1ps
// Multimode waveshaper: drive gain followed by a selectable distortion shape.
// Input stream: one signed Q1.15 sample per word on s_axis_*. Output stream:
// one signed Q5.15 shaped sample per word on m_axis_*, saturated at the range
// ends, in the same order as the inputs.
// Configuration: cfg_* writes drive_gain (index 0, unsigned Q4.12) and
// shape_mode (index 1: bypass, hard clip, soft knee, exponential, full and
// half rectifier; codes 6 and 7 bypass). Other indexes are dropped. cfg_ready
// is always high; write only while no sample is in flight.
// A sample passes through six register stages from the input accept to
// m_axis_tvalid (multiply, round, knee and table lookup, products, divide
// and interpolate, select and saturate). Throughput: one sample per clock,
// as every stage advances in each cycle the receiver takes a word.
// Reset clears every stage valid and loads gain 1.0 with hard clip mode.
// When the receiver stalls, each stage holds its word while the stages
// behind it keep filling bubbles; s_axis_tready drops only once the whole
// pipe is full.
module multimode_waveshaper_distortion_unit
  import mwd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // [15:0] sample_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,   // [19:0] sample_out, [23:20] zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [GAIN_W-1:0] drive_gain;
  logic [MODE_W-1:0] shape_mode;

  logic              gain_valid;
  logic              gain_ready;
  gain_word_t        gain_word;
  logic              shape_valid;
  logic              shape_ready;
  shape_word_t       shape_word;
  logic [OUT_W-1:0]  sample_out;

  // Configuration registers: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= DRIVE_GAIN_RST;
      shape_mode <= SHAPE_MODE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DRIVE_GAIN) begin
        drive_gain <= cfg_data[GAIN_W-1:0];
      end
      if (cfg_index == CFG_SHAPE_MODE) begin
        shape_mode <= cfg_data[MODE_W-1:0];
      end
    end
  end

  // Multiply by drive and round to Q.15
  mwd_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (s_axis_tdata),
    .gain      (drive_gain),
    .mode      (shape_mode),
    .out_valid (gain_valid),
    .out_ready (gain_ready),
    .out_word  (gain_word)
  );

  // Soft knee curve and exponential interpolation
  mwd_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gain_valid),
    .in_ready  (gain_ready),
    .in_word   (gain_word),
    .out_valid (shape_valid),
    .out_ready (shape_ready),
    .out_word  (shape_word)
  );

  // Mode select, sign, saturate and hold the output word
  mwd_select u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (shape_valid),
    .in_ready   (shape_ready),
    .in_word    (shape_word),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .sample_out (sample_out)
  );

  assign m_axis_tdata = {4'b0000, sample_out};

endmodule

// ----- dv/waveshaper_checker.sv -----
`timescale 1ns / 1ps
module waveshaper_checker
  import mwd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [23:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     outstanding
);

  localparam longint CLIP     = longint'(HALF_Q15);
  localparam longint KNEE_LO  = longint'(THIRD_Q15);
  localparam longint KNEE_HI  = longint'(TWO_THIRDS_Q15);
  localparam longint SAT_HI   = longint'(OUT_MAX);
  localparam longint SAT_LO   = longint'(OUT_MIN);
  localparam longint EXP_SPAN = longint'(1) << EXP_FRAC_W;
  localparam int     DUE_DEPTH = 1024;

  longint decay_tab [0:EXP_TABLE_DEPTH];
  logic signed [OUT_W-1:0] shaped_due [0:DUE_DEPTH-1];
  int due_wr;
  int due_rd;
  logic [GAIN_W-1:0] gain;
  logic [MODE_W-1:0] mode;
  int mismatches;

  // 1 - exp(-x) over 0..8.0 in Q.15, from a Q32 decay ratio per table step
  initial begin
    longint unsigned step;
    longint unsigned term;
    longint unsigned e;
    longint          ratio;
    step  = (64'd8 << 32) / EXP_TABLE_DEPTH;
    term  = 64'd1 << 32;
    ratio = longint'(1) << 32;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * step) >> 32) / n;
      if (n % 2 == 1) ratio -= longint'(term);
      else ratio += longint'(term);
    end
    e = 64'd1 << 32;
    decay_tab[0] = 0;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      e = (e * unsigned'(ratio) + (64'd1 << 31)) >> 32;
      decay_tab[k] = longint'((((64'd1 << 32) - e) * 64'd32768 + (64'd1 << 31)) >> 32);
    end
  end

  function automatic logic signed [OUT_W-1:0] shape_sample(
    input logic signed [SAMPLE_W-1:0] x,
    input logic [GAIN_W-1:0]          g,
    input logic [MODE_W-1:0]          m
  );
    longint v, a, y, u, s, i, f;
    v = (longint'(x) * longint'(g) + 2048) >>> 12;
    a = (v < 0) ? -v : v;
    case (m)
      MODE_HARD: y = (v > CLIP) ? CLIP : ((v < -CLIP) ? -CLIP : v);
      MODE_SOFT: begin
        if (a <= KNEE_LO) y = a;
        else if (a > KNEE_HI) y = CLIP;
        else begin
          u = 65536 - 3 * a;
          y = (3 * (longint'(1) << 30) - u * u + 98304) / 196608;
        end
        if (v < 0) y = -y;
      end
      MODE_EXP: begin
        if (a >= EXP_SPAN) y = decay_tab[EXP_TABLE_DEPTH];
        else begin
          s = a * EXP_TABLE_DEPTH;
          i = s / EXP_SPAN;
          f = s % EXP_SPAN;
          y = decay_tab[i]
              + ((decay_tab[i+1] - decay_tab[i]) * f + EXP_SPAN / 2) / EXP_SPAN;
        end
        if (v < 0) y = -y;
      end
      MODE_FULL: y = a;
      MODE_HALF: y = (v > 0) ? v : 0;
      default:   y = v;
    endcase
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    return OUT_W'(y);
  endfunction

  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    logic [23:0] want_word;
    if (rst) begin
      gain = DRIVE_GAIN_RST;
      mode = SHAPE_MODE_RST;
      mismatches = 0;
      due_wr = 0;
      due_rd = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DRIVE_GAIN) gain = cfg_data[GAIN_W-1:0];
        else if (cfg_index == CFG_SHAPE_MODE) mode = cfg_data[MODE_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_wr == due_rd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word %h, nothing pending", m_axis_tdata);
        end else begin
          want = shaped_due[due_rd % DUE_DEPTH];
          due_rd++;
          want_word = '0;
          want_word[OUT_W-1:0] = want;
          if (m_axis_tdata !== want_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out mismatch: expected %0d (%h) got %0d (%h)",
                       want, want_word, $signed(m_axis_tdata[OUT_W-1:0]), m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        shaped_due[due_wr % DUE_DEPTH] = shape_sample(s_axis_tdata, gain, mode);
        due_wr++;
      end
    end
    fail_count  <= mismatches;
    outstanding <= due_wr - due_rd;
  end

endmodule

// ----- dv/tb_multimode_waveshaper_distortion_unit.sv -----
`timescale 1ns / 1ps
module tb_multimode_waveshaper_distortion_unit;
  import mwd_pkg::*;

  // Far beyond the slowest correct run: ~430 words, each under heavy idling
  localparam int LIMIT = 300000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata;   // [15:0] sample_in
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [23:0]            m_axis_tdata;   // [19:0] sample_out, [23:20] zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_gap_pct;
  int sink_stall_pct;
  int cycles = 0;
  int fail_count;
  int outstanding;

  always #1 clk = ~clk;

  multimode_waveshaper_distortion_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  waveshaper_checker u_shape_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Receiver: stall at the rate the current phase asks for
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: give up on a hung pipe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_multimode_waveshaper_distortion_unit NOT OK");
      $finish;
    end
  end

  // Offer one sample word, after a random gap; leave tvalid high on return so
  // back-to-back words need no second assignment in the same step
  task automatic send_sample(input logic [15:0] word);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop tvalid and hold until every predicted word has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Hold cfg_valid high across a burst; the caller lowers it afterwards
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram both registers with the pipe empty, sometimes slipping in a
  // write to an index the block must ignore
  task automatic set_shape(input logic [GAIN_W-1:0] gain, input logic [CFG_DATA_W-1:0] mode_word);
    drain();
    write_reg(CFG_DRIVE_GAIN, gain);
    if ($urandom_range(1) == 1)
      write_reg(CFG_INDEX_W'($urandom_range(2, 2**CFG_INDEX_W - 1)), 16'($urandom));
    write_reg(CFG_SHAPE_MODE, mode_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [GAIN_W-1:0] gain;
    logic [15:0]       word;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (unity gain, hard clip): full scale and just past the clip
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'd16385);
    send_sample(-16'sd16385);

    // Soft knee at unity gain, mode written with junk in the upper bits: probe
    // both thresholds, exactly on each when positive and just past each when negative
    set_shape(16'd4096, {13'h1FFF, MODE_SOFT});
    send_sample(16'd10923);
    send_sample(-16'sd10924);
    send_sample(16'd21845);
    send_sample(-16'sd21846);

    // Largest gain, every mode code including the two spare ones: output
    // saturation and the exponential past the end of its table
    for (int m = 0; m < 8; m++) begin
      set_shape(16'hFFFF, CFG_DATA_W'(m));
      send_sample(16'h8000);
      send_sample(16'h7FFF);
    end

    // Random blocks, rotating through the idling phases
    for (int blk = 0; blk < 16; blk++) begin
      case (blk % 4)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 78; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 78; end
        default: begin send_gap_pct = 19; sink_stall_pct = 19; end
      endcase
      case ($urandom_range(5))
        0: gain = '0;
        1: gain = 16'd40960;
        2: gain = '1;
        3: gain = DRIVE_GAIN_RST;
        4: gain = 16'($urandom);
        default: gain = 16'($urandom_range(0, 40960));
      endcase
      set_shape(gain, {($urandom_range(1) == 1) ? 13'($urandom) : 13'd0,
                       3'($urandom_range(0, 7))});
      repeat (25) begin
        case ($urandom_range(9))
          0: word = 16'h8000;
          1: word = 16'h7FFF;
          2: word = 16'($urandom_range(0, 2000)) - 16'd1000;
          default: word = 16'($urandom);
        endcase
        send_sample(word);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_multimode_waveshaper_distortion_unit OK");
    end else begin
      $display("tb_multimode_waveshaper_distortion_unit NOT OK");
    end
    $finish;
  end

endmodule
